@@ rtl/core/rsc_pkg.sv @@
// Shared constants, types and digit helper functions for the radix string converter.
package rsc_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_DIGITS_DEF  = 32;

    localparam int BASE_W     = 5;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 8;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic [BASE_W-1:0] SOURCE_BASE_RST = 5'd10;
    localparam logic [BASE_W-1:0] TARGET_BASE_RST = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MIN        = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX        = 5'd16;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

    // Register index codes, taken from paddr[2].
    localparam logic REG_SOURCE_BASE = 1'b0;
    localparam logic REG_TARGET_BASE = 1'b1;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        begin
            if (b < BASE_MIN) begin
                r = BASE_MIN;
            end else if (b > BASE_MAX) begin
                r = BASE_MAX;
            end else begin
                r = b;
            end
            return r;
        end
    endfunction

    function automatic logic [DIGIT_W-1:0] decode_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] t;
        logic [DIGIT_W-1:0] r;
        begin
            r = '0;
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                t = c - CHAR_ZERO;
                r = t[DIGIT_W-1:0];
            end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
                t = c - CHAR_UPPER_A;
                r = t[DIGIT_W-1:0] + DIGIT_TEN;
            end
            return r;
        end
    endfunction

    function automatic logic [CHAR_W-1:0] encode_digit(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] r;
        begin
            if (d < DIGIT_TEN) begin
                r = CHAR_ZERO + CHAR_W'(d);
            end else begin
                r = CHAR_UPPER_A + CHAR_W'(d - DIGIT_TEN);
            end
            return r;
        end
    endfunction

endpackage

@@ rtl/core/rsc_divider.sv @@
// Shared restoring divider: one quotient bit per cycle, small divisor.
module rsc_divider #(
    parameter int VALUE_WIDTH = rsc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [VALUE_WIDTH-1:0]      dividend,
    input  logic [rsc_pkg::BASE_W-1:0]  divisor,
    output logic [VALUE_WIDTH-1:0]      quotient,
    output logic [rsc_pkg::DIGIT_W-1:0] remainder,
    output rsc_pkg::div_status_t        status
);
    import rsc_pkg::*;

    localparam int CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_WIDTH - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [DIGIT_W-1:0]   rem_reg, rem_next;
    logic [BASE_W-1:0]    div_reg, div_next;
    logic [BASE_W-1:0]    trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign fits  = (trial >= div_reg);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[VALUE_WIDTH-2:0], fits};
            if (fits) begin
                rem_next = DIGIT_W'(trial - div_reg);
            end else begin
                rem_next = trial[DIGIT_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ rtl/core/rsc_digit_buf.sv @@
// Digit buffer memory: one write port, one registered read port.
module rsc_digit_buf #(
    parameter int MAX_DIGITS = rsc_pkg::MAX_DIGITS_DEF
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_DIGITS)-1:0] wr_addr,
    input  logic [rsc_pkg::DIGIT_W-1:0]   wr_data,
    input  logic [$clog2(MAX_DIGITS)-1:0] rd_addr,
    output logic [rsc_pkg::DIGIT_W-1:0]   rd_data
);
    import rsc_pkg::*;

    logic [DIGIT_W-1:0] mem [MAX_DIGITS];
    logic [DIGIT_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/radix_string_converter_top.sv @@
// Radix string converter top level: APB registers, digit folding and conversion sequencer.
// Each digit transfer not marked last is folded into the accumulator and the block stays ready.
// A last digit starts the conversion: for each target digit the sequencer starts the
// shared one-bit-per-cycle divider and waits; each emitted digit is read, then held until m_ready.
// The block takes no input transfer from the last digit until the final result transfer.
// Reset (aresetn low at a clock edge) clears the accumulator, flags, sequencer and registers.
module radix_string_converter_top #(
    parameter int VALUE_WIDTH = rsc_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = rsc_pkg::MAX_DIGITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input channel.
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rsc_pkg::CHAR_W-1:0]     s_digit_char,
    input  logic                           s_is_last,
    // Result channel.
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rsc_pkg::CHAR_W-1:0]     m_out_char,
    output logic                           m_out_last,
    output logic                           m_overflowed,
    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rsc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [rsc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [rsc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import rsc_pkg::*;

    localparam int IDX_W   = $clog2(MAX_DIGITS);
    localparam int COUNT_W = $clog2(MAX_DIGITS + 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_DIGITS);
    localparam int PROD_W  = VALUE_WIDTH + BASE_W;
    localparam int SUM_W   = PROD_W + 1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_START  = 5'b00010,
        ST_DIVIDE = 5'b00100,
        ST_READ   = 5'b01000,
        ST_SEND   = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [BASE_W-1:0]    source_base_reg, target_base_reg;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic                 ovf_seen_reg, ovf_seen_next;
    logic                 ovf_out_reg, ovf_out_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;

    // APB registers. The write lands on the access cycle; the byte offset is ignored.
    logic cfg_write;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_base_reg <= SOURCE_BASE_RST;
            target_base_reg <= TARGET_BASE_RST;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_SOURCE_BASE: source_base_reg <= pwdata[BASE_W-1:0];
                REG_TARGET_BASE: target_base_reg <= pwdata[BASE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SOURCE_BASE: prdata = CFG_DATA_W'(source_base_reg);
            REG_TARGET_BASE: prdata = CFG_DATA_W'(target_base_reg);
            default:         prdata = '0;
        endcase
    end

    // Digit fold: acc * base + digit, with the carry-out bits flagging a wrap.
    logic [DIGIT_W-1:0] in_digit;
    logic [PROD_W-1:0]  fold_prod;
    logic [SUM_W-1:0]   fold_sum;
    logic               fold_ovf;

    assign in_digit  = decode_char(s_digit_char);
    assign fold_prod = PROD_W'(acc_reg) * PROD_W'(clamp_base(source_base_reg));
    assign fold_sum  = SUM_W'(fold_prod) + SUM_W'(in_digit);
    assign fold_ovf  = |fold_sum[SUM_W-1:VALUE_WIDTH];

    // Shared divider and digit store.
    logic                 div_start;
    logic [VALUE_WIDTH-1:0] div_quotient;
    logic [DIGIT_W-1:0]   div_remainder;
    div_status_t          div_status;

    rsc_divider #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (acc_reg),
        .divisor   (clamp_base(target_base_reg)),
        .quotient  (div_quotient),
        .remainder (div_remainder),
        .status    (div_status)
    );

    logic               buf_wr_en;
    logic [DIGIT_W-1:0] buf_rd_data;

    rsc_digit_buf #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_digit_buf (
        .aclk    (aclk),
        .wr_en   (buf_wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (div_remainder),
        .rd_addr (rd_idx_reg),
        .rd_data (buf_rd_data)
    );

    // Sequencer. Digits are produced least significant first into the buffer and
    // then read back from the top entry down, so the output is most significant first.
    always_comb begin
        state_next    = state_reg;
        acc_next      = acc_reg;
        ovf_seen_next = ovf_seen_reg;
        ovf_out_next  = ovf_out_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        div_start     = 1'b0;
        buf_wr_en     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    acc_next      = fold_sum[VALUE_WIDTH-1:0];
                    ovf_seen_next = ovf_seen_reg | fold_ovf;
                    if (s_is_last) begin
                        count_next = '0;
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                div_start  = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (div_status.done) begin
                    buf_wr_en  = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (div_quotient != '0 && count_next < COUNT_MAX) begin
                        acc_next   = div_quotient;
                        state_next = ST_START;
                    end else begin
                        // Conversion done: clear for the next number and start readback.
                        rd_idx_next   = count_reg[IDX_W-1:0];
                        ovf_out_next  = ovf_seen_reg;
                        acc_next      = '0;
                        ovf_seen_next = 1'b0;
                        state_next    = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_ready) begin
                    if (rd_idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        rd_idx_next = rd_idx_reg - 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            acc_reg      <= '0;
            ovf_seen_reg <= 1'b0;
            ovf_out_reg  <= 1'b0;
            count_reg    <= '0;
            rd_idx_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            acc_reg      <= acc_next;
            ovf_seen_reg <= ovf_seen_next;
            ovf_out_reg  <= ovf_out_next;
            count_reg    <= count_next;
            rd_idx_reg   <= rd_idx_next;
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = (state_reg == ST_SEND);
    assign m_out_char   = encode_digit(buf_rd_data);
    assign m_out_last   = (rd_idx_reg == '0);
    assign m_overflowed = ovf_out_reg;

    // The input and result channels are never open in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_ready && m_valid))
        else $error("input and result channels open together");

    // A last digit transfer closes the input channel for the conversion.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_is_last) |=> (state_reg == ST_START))
        else $error("last digit did not start a conversion");

    // The final result transfer reopens the input channel with a cleared accumulator.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_out_last) |=> (s_ready && acc_reg == '0 && !ovf_seen_reg))
        else $error("block not cleared after the final result transfer");

    // The divider only reports completion while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.done |-> (state_reg == ST_DIVIDE))
        else $error("divider completion outside the divide state");

    // A divide is never started while the divider is still busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_status.busy)
        else $error("divider restarted while busy");

endmodule
